### rtl/rrpd_pkg.sv
// Package for the receive ring packet deframer.
// Holds ring constants, header byte codes, phase type and the result word struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrpd_pkg;

	localparam int unsigned RING_SIZE = 8192;
	localparam int unsigned OFS_W     = 14;

	localparam logic [15:0] BUSY_LEN       = 16'hFFF0;
	localparam logic [15:0] CAPR_BIAS      = 16'h0010;
	localparam logic [15:0] MAX_LENGTH_RST = 16'd1518;
	localparam logic [15:0] CRC_BYTES      = 16'd4;
	localparam logic [15:0] HDR_BYTES      = 16'd4;
	localparam logic [15:0] ALIGN_ROUND    = 16'd3;

	// header byte position
	localparam logic [1:0] HDR_STAT_LO = 2'd0;
	localparam logic [1:0] HDR_STAT_HI = 2'd1;
	localparam logic [1:0] HDR_LEN_LO  = 2'd2;
	localparam logic [1:0] HDR_LEN_HI  = 2'd3;

	typedef enum logic {
		PH_HEADER  = 1'b0,
		PH_PAYLOAD = 1'b1
	} phase_t;

	typedef struct packed {
		logic             out_valid;
		logic [7:0]       out_byte;
		logic             frame_end;
		logic             frame_good;
		logic [15:0]      frame_length;
		logic             capr_write;
		logic [15:0]      capr_value;
		logic             not_ready;
		logic [OFS_W-1:0] read_offset;
	} res_t;

endpackage

`default_nettype wire

### rtl/rx_ring_packet_deframer.sv
// Receive ring packet deframer top level: header parse, payload delivery, next offset.
// Depends on rrpd_pkg.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------
//   item     | item_valid / item_stall      | ring_empty, ring_byte
//   result   | result_valid / result_stall  | out_valid .. read_offset (one per item)
//   config   | max_length_we                | max_length_wdata
//
// One ring byte per cycle while item_stall is low; each result word is registered.
// All per-item work is one combinational pass from state and input into the result register.
// A skid register holds one word while result_stall is high; item_stall rises only when
// the skid register is full.
// arst_n clears all state but the result and skid payload words; max_length returns to 1518.
`timescale 1ns / 1ps
`default_nettype none

module rx_ring_packet_deframer (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          max_length_we,
	input  wire  [15:0]                  max_length_wdata,
	input  wire                          item_valid,
	output logic                         item_stall,
	input  wire                          ring_empty,
	input  wire  [7:0]                   ring_byte,
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic                         out_valid,
	output logic [7:0]                   out_byte,
	output logic                         frame_end,
	output logic                         frame_good,
	output logic [15:0]                  frame_length,
	output logic                         capr_write,
	output logic [15:0]                  capr_value,
	output logic                         not_ready,
	output logic [rrpd_pkg::OFS_W-1:0]   read_offset
);
	import rrpd_pkg::*;

	// state
	logic [15:0]      max_length_q;
	phase_t           phase_q, phase_d;
	logic [1:0]       hdr_cnt_q, hdr_cnt_d;
	logic [15:0]      status_q, status_d;
	logic [15:0]      length_q, length_d;
	logic [OFS_W-1:0] pkt_start_q, pkt_start_d;
	logic [OFS_W-1:0] read_pos_q, read_pos_d;
	logic [15:0]      dlv_cnt_q, dlv_cnt_d;
	logic [15:0]      dlv_total_q, dlv_total_d;

	// output register and skid
	res_t res_q, skid_q, res_d;
	logic res_valid_q, skid_valid_q;
	logic in_fire;

	// decode
	logic [15:0]      len_full;
	logic             len_busy;
	logic             frm_good;
	logic [15:0]      flen_raw, flen;
	logic [15:0]      nxt16;
	logic [OFS_W-1:0] nxt_ofs;
	logic [15:0]      cnt_inc;
	logic             hdr_last;
	logic             hdr_close;
	logic             pay_close;

	assign item_stall = skid_valid_q;
	assign in_fire    = item_valid && !skid_valid_q;

	always_comb begin
		len_full = (hdr_cnt_q == HDR_LEN_HI) ? {ring_byte, length_q[7:0]} : length_q;
		len_busy = (len_full == 16'd0) || (len_full == BUSY_LEN);
		frm_good = status_q[0] && (len_full >= CRC_BYTES);
		flen_raw = len_full - CRC_BYTES;
		flen     = frm_good ? ((flen_raw > max_length_q) ? max_length_q : flen_raw) : 16'd0;
		// dword align past header and frame, on 16 bits
		nxt16    = ({2'b00, pkt_start_q} + len_full + HDR_BYTES + ALIGN_ROUND) & ~16'd3;
		nxt_ofs  = OFS_W'(nxt16 % RING_SIZE);
		cnt_inc  = dlv_cnt_q + 16'd1;
		hdr_last = (phase_q == PH_HEADER) && (hdr_cnt_q == HDR_LEN_HI);
		hdr_close = hdr_last && !len_busy && !(frm_good && (flen != 16'd0));
		pay_close = (phase_q == PH_PAYLOAD) && (cnt_inc >= dlv_total_q);
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		status_d    = status_q;
		length_d    = length_q;
		pkt_start_d = pkt_start_q;
		read_pos_d  = read_pos_q;
		dlv_cnt_d   = dlv_cnt_q;
		dlv_total_d = dlv_total_q;
		if (!ring_empty) begin
			if (phase_q == PH_HEADER) begin
				case (hdr_cnt_q)
					HDR_STAT_LO: status_d = {8'h00, ring_byte};
					HDR_STAT_HI: status_d = {ring_byte, status_q[7:0]};
					HDR_LEN_LO:  length_d = {8'h00, ring_byte};
					default:     length_d = len_full;
				endcase
				if (!hdr_last) begin
					hdr_cnt_d  = hdr_cnt_q + 2'd1;
					read_pos_d = read_pos_q + OFS_W'(1);
				end else if (len_busy) begin
					hdr_cnt_d  = HDR_STAT_LO;
					read_pos_d = pkt_start_q;
				end else if (!hdr_close) begin
					phase_d     = PH_PAYLOAD;
					hdr_cnt_d   = HDR_STAT_LO;
					dlv_cnt_d   = 16'd0;
					dlv_total_d = flen;
					read_pos_d  = pkt_start_q + OFS_W'(HDR_BYTES);
				end
			end else begin
				dlv_cnt_d = cnt_inc;
				if (!pay_close) begin
					read_pos_d = read_pos_q + OFS_W'(1);
				end
			end
			if (hdr_close || pay_close) begin
				pkt_start_d = nxt_ofs;
				read_pos_d  = nxt_ofs;
				phase_d     = PH_HEADER;
				hdr_cnt_d   = HDR_STAT_LO;
				dlv_cnt_d   = 16'd0;
				dlv_total_d = 16'd0;
			end
		end
	end

	// result word
	always_comb begin
		res_d = '0;
		if (!ring_empty) begin
			if (phase_q == PH_PAYLOAD) begin
				res_d.out_valid = 1'b1;
				res_d.out_byte  = ring_byte;
			end
			res_d.not_ready = hdr_last && len_busy;
			if (hdr_close || pay_close) begin
				res_d.frame_end    = 1'b1;
				res_d.frame_good   = pay_close || frm_good;
				res_d.frame_length = pay_close ? dlv_total_q : 16'd0;
				res_d.capr_write   = 1'b1;
				res_d.capr_value   = {{(16-OFS_W){1'b0}}, nxt_ofs} - CAPR_BIAS;
			end
		end
		res_d.read_offset = read_pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
			phase_q      <= PH_HEADER;
			hdr_cnt_q    <= HDR_STAT_LO;
			status_q     <= '0;
			length_q     <= '0;
			pkt_start_q  <= '0;
			read_pos_q   <= '0;
			dlv_cnt_q    <= '0;
			dlv_total_q  <= '0;
		end else begin
			if (max_length_we) begin
				max_length_q <= max_length_wdata;
			end
			if (in_fire) begin
				phase_q     <= phase_d;
				hdr_cnt_q   <= hdr_cnt_d;
				status_q    <= status_d;
				length_q    <= length_d;
				pkt_start_q <= pkt_start_d;
				read_pos_q  <= read_pos_d;
				dlv_cnt_q   <= dlv_cnt_d;
				dlv_total_q <= dlv_total_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || !result_stall) begin
				if (skid_valid_q) begin
					res_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					res_valid_q <= in_fire;
				end
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!res_valid_q || !result_stall) begin
			res_q <= skid_valid_q ? skid_q : res_d;
		end else if (in_fire) begin
			skid_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign out_valid    = res_q.out_valid;
	assign out_byte     = res_q.out_byte;
	assign frame_end    = res_q.frame_end;
	assign frame_good   = res_q.frame_good;
	assign frame_length = res_q.frame_length;
	assign capr_write   = res_q.capr_write;
	assign capr_value   = res_q.capr_value;
	assign not_ready    = res_q.not_ready;
	assign read_offset  = res_q.read_offset;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid word held while result register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(result_stall))
		else $error("skid filled without a downstream stall");

	a_payload_total: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (dlv_total_q != 16'd0) && (dlv_cnt_q < dlv_total_q))
		else $error("payload phase with no bytes left to deliver");

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |->
			(read_pos_q == pkt_start_q + OFS_W'(hdr_cnt_q)) && (dlv_cnt_q == 16'd0))
		else $error("header read position out of step with header count");

	a_end_writes_capr: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.frame_end) |-> res_q.capr_write && !res_q.not_ready)
		else $error("frame end without consumed pointer write");
`endif

endmodule

`default_nettype wire

### tb/sv/rx_ring_packet_deframer_test.sv
// Self-checking bench for rx_ring_packet_deframer: feeds ring byte streams built from
// headers and payloads, predicts every result word and checks it field by field.
// Depends on rrpd_pkg and the rx_ring_packet_deframer RTL.
`timescale 1ns / 1ps

module rx_ring_packet_deframer_test;
	import rrpd_pkg::*;

	typedef struct packed {
		logic       empty;
		logic [7:0] data;
	} ring_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic max_length_we = 1'b0;
	logic [15:0] max_length_wdata = 16'h0000;
	logic item_valid = 1'b0;
	logic item_stall;
	logic ring_empty = 1'b0;
	logic [7:0] ring_byte = 8'h00;
	logic result_valid;
	logic result_stall = 1'b0;
	logic out_valid;
	logic [7:0] out_byte;
	logic frame_end;
	logic frame_good;
	logic [15:0] frame_length;
	logic capr_write;
	logic [15:0] capr_value;
	logic not_ready;
	logic [OFS_W-1:0] read_offset;

	rx_ring_packet_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.max_length_we(max_length_we),
		.max_length_wdata(max_length_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.ring_empty(ring_empty),
		.ring_byte(ring_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.frame_end(frame_end),
		.frame_good(frame_good),
		.frame_length(frame_length),
		.capr_write(capr_write),
		.capr_value(capr_value),
		.not_ready(not_ready),
		.read_offset(read_offset)
	);

	// deframer shadow state
	phase_t           fr_phase = PH_HEADER;
	logic [1:0]       hdr_pos = HDR_STAT_LO;
	logic [15:0]      stat_word = 16'h0000;
	logic [15:0]      len_word = 16'h0000;
	logic [OFS_W-1:0] pkt_base = '0;
	logic [OFS_W-1:0] rd_ofs = '0;
	logic [15:0]      sent_cnt = 16'h0000;
	logic [15:0]      sent_goal = 16'h0000;
	logic [15:0]      lim = MAX_LENGTH_RST;

	ring_item_t ring_feed[$];
	res_t       due_words[$];
	ring_item_t feed_word;
	res_t       got_word;
	res_t       want_word;
	int         feed_gap = 0;
	int         drain_hold = 0;
	int         jam_left = 0;
	bit         jam_done = 1'b0;
	bit         feed_quiet = 1'b0;
	bit         drain_quiet = 1'b0;
	int         fed_items = 0;
	int         words_seen = 0;
	int         mismatches = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic string show(input res_t w);
		return $sformatf("ov=%0d ob=%02h fe=%0d fg=%0d fl=%0d cw=%0d cv=%04h nr=%0d ro=%0d",
			w.out_valid, w.out_byte, w.frame_end, w.frame_good, w.frame_length,
			w.capr_write, w.capr_value, w.not_ready, w.read_offset);
	endfunction

	// packet done: jump to next dword boundary past header and frame, report capr
	function automatic void close_packet(inout res_t w, input logic good,
			input logic [15:0] delivered);
		int unsigned nxt;
		nxt = pkt_base + len_word + HDR_BYTES + ALIGN_ROUND;
		nxt = {nxt[15:2], 2'b00} % RING_SIZE;
		w.frame_end = 1'b1;
		w.frame_good = good;
		w.frame_length = delivered;
		w.capr_write = 1'b1;
		w.capr_value = nxt[15:0] - CAPR_BIAS;
		pkt_base = nxt[OFS_W-1:0];
		rd_ofs = nxt[OFS_W-1:0];
		fr_phase = PH_HEADER;
		hdr_pos = HDR_STAT_LO;
		sent_cnt = 16'h0000;
		sent_goal = 16'h0000;
	endfunction

	function automatic res_t deframe_step(input logic empty, input logic [7:0] b);
		res_t        w;
		logic        ok;
		logic [15:0] flen;
		w = '0;
		if (empty) begin
			w.read_offset = rd_ofs;
			return w;
		end
		if (fr_phase == PH_HEADER) begin
			case (hdr_pos)
				HDR_STAT_LO: stat_word = {8'h00, b};
				HDR_STAT_HI: stat_word[15:8] = b;
				HDR_LEN_LO: len_word = {8'h00, b};
				default: len_word[15:8] = b;
			endcase
			if (hdr_pos != HDR_LEN_HI) begin
				hdr_pos = hdr_pos + 2'd1;
				rd_ofs = rd_ofs + 1'b1;
			end else if (len_word == 16'h0000 || len_word == BUSY_LEN) begin
				// still being written by the device: go back to the header
				w.not_ready = 1'b1;
				hdr_pos = HDR_STAT_LO;
				rd_ofs = pkt_base;
			end else begin
				ok = stat_word[0] && len_word >= CRC_BYTES;
				flen = 16'h0000;
				if (ok) begin
					flen = len_word - CRC_BYTES;
					if (flen > lim)
						flen = lim;
				end
				if (ok && flen != 16'h0000) begin
					fr_phase = PH_PAYLOAD;
					hdr_pos = HDR_STAT_LO;
					sent_cnt = 16'h0000;
					sent_goal = flen;
					rd_ofs = pkt_base + HDR_BYTES;
				end else begin
					close_packet(w, ok, 16'h0000);
				end
			end
		end else begin
			w.out_valid = 1'b1;
			w.out_byte = b;
			sent_cnt = sent_cnt + 16'd1;
			if (sent_cnt >= sent_goal)
				close_packet(w, 1'b1, sent_goal);
			else
				rd_ofs = rd_ofs + 1'b1;
		end
		w.read_offset = rd_ofs;
		return w;
	endfunction

	// payload bytes the block will ask for after this header
	function automatic int payload_len(input logic [15:0] st, input logic [15:0] ln);
		if (!st[0] || ln < CRC_BYTES || ln == BUSY_LEN)
			return 0;
		return (ln - CRC_BYTES > lim) ? lim : ln - CRC_BYTES;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		logic [7:0] junk;
		junk = $urandom;
		if ($urandom_range(0, 9) == 0)
			ring_feed.push_back({1'b1, junk});
		ring_feed.push_back({1'b0, b});
		fed_items++;
	endtask

	task automatic push_header(input logic [15:0] st, input logic [15:0] ln);
		push_byte(st[7:0]);
		push_byte(st[15:8]);
		push_byte(ln[7:0]);
		push_byte(ln[15:8]);
	endtask

	task automatic push_frame(input logic [15:0] st, input logic [15:0] ln);
		int n;
		n = payload_len(st, ln);
		push_header(st, ln);
		repeat (n)
			push_byte($urandom);
	endtask

	task automatic random_frame();
		int          pick;
		logic [15:0] st;
		logic [15:0] ln;
		pick = $urandom_range(0, 99);
		st = $urandom;
		ln = $urandom;
		if (pick < 60) begin
			st[0] = 1'b1;
			ln = (pick < 5) ? $urandom_range(4, 300) : $urandom_range(4, 24);
		end else if (pick < 75) begin
			st[0] = 1'b0;
		end else if (pick < 85) begin
			ln = pick[0] ? BUSY_LEN : 16'h0000;
		end else if (pick < 90) begin
			st[0] = 1'b1;
			ln = $urandom_range(0, 3);
		end else if (payload_len(st, ln) > 300) begin
			st[0] = 1'b0;
		end
		push_frame(st, ln);
	endtask

	task automatic set_max_length(input logic [15:0] v);
		@(posedge clk);
		max_length_we <= 1'b1;
		max_length_wdata <= v;
		@(posedge clk);
		max_length_we <= 1'b0;
		lim = v;
	endtask

	task automatic settle();
		while (ring_feed.size() != 0 || item_valid || due_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			ring_empty <= 1'b0;
			ring_byte <= 8'h00;
			feed_gap = 0;
		end else begin
			if (item_valid && !item_stall) begin
				due_words.push_back(deframe_step(ring_empty, ring_byte));
				if ($urandom_range(0, 39) == 0)
					feed_quiet = !feed_quiet;
				feed_gap = feed_quiet ? 0 : $urandom_range(0, 10);
			end
			if (!item_valid || !item_stall) begin
				if (feed_gap > 0) begin
					feed_gap--;
					item_valid <= 1'b0;
				end else if (ring_feed.size() != 0) begin
					feed_word = ring_feed.pop_front();
					item_valid <= 1'b1;
					ring_empty <= feed_word.empty;
					ring_byte <= feed_word.data;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off so the skid fills and the input stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jam_left = 0;
		end else if (!jam_done && words_seen >= 300) begin
			jam_left = 80;
			jam_done = 1'b1;
		end else if (jam_left > 0) begin
			jam_left--;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			drain_hold = 0;
		end else begin
			if (result_valid && !result_stall) begin
				got_word = {out_valid, out_byte, frame_end, frame_good, frame_length,
					capr_write, capr_value, not_ready, read_offset};
				words_seen++;
				if (due_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: %s", show(got_word));
				end else begin
					want_word = due_words.pop_front();
					if (got_word !== want_word) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("word %0d mismatch", words_seen);
							$display("  expected %s", show(want_word));
							$display("  actual   %s", show(got_word));
						end
					end
				end
				if ($urandom_range(0, 39) == 0)
					drain_quiet = !drain_quiet;
				drain_hold = drain_quiet ? 0 : $urandom_range(0, 10);
			end
			if (drain_hold > 0) begin
				drain_hold--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= (jam_left > 0);
			end
		end
	end

	initial begin
		int          step;
		int          mark;
		logic [15:0] v;
		logic [15:0] jump;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default max length
		ring_feed.push_back({1'b1, 8'hA5});
		push_header(16'h0001, 16'd6);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_header(16'h0001, 16'h0000);
		push_header(16'h0021, BUSY_LEN);
		push_header(16'h0000, 16'd64);
		push_header(16'h0001, 16'd3);
		push_header(16'h0001, 16'd4);
		push_header(16'hFFFF, 16'd5);
		push_byte(8'h80);
		push_header(16'hFFFE, 16'hFFFF);
		settle();

		for (step = 0; step < 6; step++) begin
			case (step)
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				2: v = 16'd5;
				3: v = 16'd1;
				4: v = MAX_LENGTH_RST;
				default: v = $urandom_range(2, 200);
			endcase
			set_max_length(v);
			if (v == 16'h0000)
				push_frame(16'h0001, 16'd100);
			if (v == 16'd5)
				push_frame(16'h0001, 16'hFFFF);
			if (v == MAX_LENGTH_RST)
				push_frame(16'h0001, 16'd24);
			if (v == 16'hFFFF) begin
				// bad frame that lands the next packet near the ring end, then one
				// whose payload runs past the ring size into the slack area
				jump = (16'd8000 - {2'b00, pkt_base} - HDR_BYTES) & 16'h1FFF;
				if (jump == 16'h0000)
					jump = 16'h2000;
				push_frame(16'h0000, jump);
				push_frame(16'h0001, 16'd220);
			end
			mark = fed_items;
			while (fed_items - mark < 35)
				random_frame();
			settle();
		end

		if (mismatches == 0 && due_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
rtl/rrpd_pkg.sv
rtl/rx_ring_packet_deframer.sv
tb/sv/rx_ring_packet_deframer_test.sv
